[rtl/mlf_pkg.sv]
// mlf_pkg: shared types, constants and helpers for the mac learning forwarder
// no dependencies; imported by the index unit and the top level
`default_nettype none

package mlf_pkg;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 5;
  localparam int MASK_W  = 32;
  localparam int FOLD_W  = 16;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int PORT_COUNT_DEF  = 32;

  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  // one table entry: valid, full mac tag, learned port
  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  tag;
    logic [PORT_W-1:0] port;
  } mlf_entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SIDX,
    ST_DIDX,
    ST_LOOK,
    ST_DONE
  } mlf_state_t;

  // xor-fold of a mac into 16 bits
  function automatic logic [FOLD_W-1:0] mac_fold(input logic [MAC_W-1:0] mac);
    mac_fold = mac[15:0] ^ mac[31:16] ^ mac[47:32];
  endfunction

endpackage

`default_nettype wire

[rtl/mlf_ifs.sv]
// mlf_ifs: valid/ready channel interfaces for frame beats, decision beats and config
// no dependencies
`default_nettype none

interface mlf_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  ingress_port;
  logic [47:0] source_mac;
  logic [47:0] dest_mac;

  modport source (output valid, output ingress_port, output source_mac, output dest_mac,
                  input ready);
  modport sink (input valid, input ingress_port, input source_mac, input dest_mac,
                output ready);
endinterface

interface mlf_out_if;
  logic        valid;
  logic        ready;
  logic        is_flood;
  logic [4:0]  forward_port;
  logic [31:0] egress_mask;

  modport source (output valid, output is_flood, output forward_port, output egress_mask,
                  input ready);
  modport sink (input valid, input is_flood, input forward_port, input egress_mask,
                output ready);
endinterface

interface mlf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/mac_learning_forwarder_core.sv]
// mac_learning_forwarder_core: learning switch table, learn source then look up destination
// depends on mlf_pkg, mlf_ifs, mlf_ram and mlf_idx_unit
`default_nettype none

// One frame beat in gives one decision beat out. After reset the table is swept
// clear, one entry a cycle, through all TABLE_DEPTH entries; no frame is taken until
// then (config writes are taken at any time). A broadcast frame goes from idle
// straight to its decision. Any other frame runs through the shared hash unit twice
// (source, then destination) and the single table port twice (learn write, lookup
// read). The hash unit takes the modulo with a mask when TABLE_DEPTH is a power of
// two, otherwise with a registered reciprocal multiply, then multiply back and subtract.
// A finished decision sits in an output register, so the next frame is taken while
// it waits.
module mac_learning_forwarder_core
  import mlf_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PORT_COUNT  = PORT_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  mlf_in_if.sink   in_chan,
  mlf_out_if.source out_chan,
  mlf_cfg_if.sink  cfg_chan
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0]     LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [MASK_W-1:0] PRESENT  =
    (PORT_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << PORT_COUNT) - 64'd1);

  mlf_state_t st_r, st_nxt;

  logic [MASK_W-1:0] port_mask_r;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [PORT_W-1:0] ing_r;
  logic [MAC_W-1:0]  src_r, dst_r;
  logic [MASK_W-1:0] flood_mask_r;
  logic              res_flood_r, res_flood_nxt;
  logic [PORT_W-1:0] res_port_r, res_port_nxt;
  logic [MASK_W-1:0] res_mask_r, res_mask_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_flood_r;
  logic [PORT_W-1:0] out_port_r;
  logic [MASK_W-1:0] out_mask_r;

  logic              in_acc;
  logic              out_load;
  logic              idx_start;
  logic [MAC_W-1:0]  idx_mac;
  logic              idx_done;
  logic [AW-1:0]     idx;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  mlf_entry_t        ram_wdata, ram_rdata;
  logic              hit;
  logic [MASK_W-1:0] flood_mask;

  assign in_chan.ready = (st_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign flood_mask = port_mask_r & PRESENT & ~MASK_W'(1) & ~(MASK_W'(1) << in_chan.ingress_port);

  // shared hash unit
  mlf_idx_unit #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_idx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .mac   (idx_mac),
    .done  (idx_done),
    .idx   (idx)
  );

  // table memory
  mlf_ram #(
    .WIDTH ($bits(mlf_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign hit = ram_rdata.valid && (ram_rdata.tag == dst_r) && (ram_rdata.port != '0);

  // sequencer: clear sweep, learn, lookup, hand-off
  always_comb begin
    st_nxt        = st_r;
    clr_cnt_nxt   = clr_cnt_r;
    idx_start     = 1'b0;
    idx_mac       = in_chan.source_mac;
    ram_we        = 1'b0;
    ram_addr      = idx;
    ram_wdata     = '{valid: 1'b1, tag: src_r, port: ing_r};
    res_flood_nxt = res_flood_r;
    res_port_nxt  = res_port_r;
    res_mask_nxt  = res_mask_r;
    out_load      = 1'b0;
    unique case (st_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_IDX) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.dest_mac == BCAST_MAC) begin
            res_flood_nxt = 1'b1;
            res_port_nxt  = '0;
            res_mask_nxt  = flood_mask;
            st_nxt        = ST_DONE;
          end else begin
            idx_start = 1'b1;
            st_nxt    = ST_SIDX;
          end
        end
      end
      ST_SIDX: begin
        idx_mac = dst_r;
        if (idx_done) begin
          ram_we    = 1'b1;
          idx_start = 1'b1;
          st_nxt    = ST_DIDX;
        end
      end
      ST_DIDX: begin
        idx_mac = dst_r;
        if (idx_done) begin
          st_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        idx_mac = dst_r;
        if (hit) begin
          res_flood_nxt = 1'b0;
          res_port_nxt  = ram_rdata.port;
          res_mask_nxt  = MASK_W'(1) << ram_rdata.port;
        end else begin
          res_flood_nxt = 1'b1;
          res_port_nxt  = '0;
          res_mask_nxt  = flood_mask_r;
        end
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        idx_mac = dst_r;
        if (!out_valid_r || out_chan.ready) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_cnt_r   <= '0;
      port_mask_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) begin
        port_mask_r <= cfg_chan.data;
      end
    end
  end

  // frame and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ing_r        <= in_chan.ingress_port;
      src_r        <= in_chan.source_mac;
      dst_r        <= in_chan.dest_mac;
      flood_mask_r <= flood_mask;
    end
    res_flood_r <= res_flood_nxt;
    res_port_r  <= res_port_nxt;
    res_mask_r  <= res_mask_nxt;
    if (out_load) begin
      out_flood_r <= res_flood_r;
      out_port_r  <= res_port_r;
      out_mask_r  <= res_mask_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_flood     = out_flood_r;
  assign out_chan.forward_port = out_port_r;
  assign out_chan.egress_mask  = out_mask_r;

  // a forwarded decision names one nonzero port
  a_fwd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_flood_r |-> $onehot(out_mask_r) && (out_port_r != '0))
    else $error("forward decision without a single egress port");

  // a flood never carries a port and never goes out port zero
  a_flood_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flood_r |-> (out_port_r == '0) && !out_mask_r[0])
    else $error("flood decision malformed");

  // the table is written only by the clear sweep or the learn step
  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (st_r == ST_CLEAR) || (st_r == ST_SIDX))
    else $error("table write outside clear or learn");

  // the hash unit only reports while the sequencer waits for it
  a_idx_wait: assert property (@(posedge clk) disable iff (!rst_n)
    idx_done |-> (st_r == ST_SIDX) || (st_r == ST_DIDX))
    else $error("hash result arrived with no request pending");

  // a new decision never overwrites one still waiting
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_chan.ready)
    else $error("decision beat overwritten");

endmodule

`default_nettype wire

[rtl/mlf_ram.sv]
// mlf_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module mlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read at one address; a read during a write returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/mlf_idx_unit.sv]
// mlf_idx_unit: shared hash unit, xor-fold of a mac reduced modulo the table depth
// depends on mlf_pkg; a power-of-two depth is a mask, otherwise a reciprocal
// multiply and a multiply-back subtract, each registered
`default_nettype none

module mlf_idx_unit
  import mlf_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [MAC_W-1:0]               mac,
  output logic                                done,
  output logic      [$clog2(TABLE_DEPTH)-1:0] idx
);

  localparam int  AW   = $clog2(TABLE_DEPTH);
  localparam bit  POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  logic [FOLD_W-1:0] fold;

  assign fold = mac_fold(mac);

  generate
    if (POW2) begin : g_mask
      logic          done_r;
      logic [AW-1:0] idx_r;

      // modulo by a power of two keeps the low bits
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          idx_r <= fold[AW-1:0];
        end
      end

      assign done = done_r;
      assign idx  = idx_r;
    end else begin : g_div
      localparam int RW = 29;
      localparam int PW = FOLD_W + RW;
      localparam int QW = PW - 32;
      localparam int MW = QW + AW + 1;
      localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << 32) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
      localparam logic [AW:0] DEPTH_W = (AW+1)'(TABLE_DEPTH);

      logic              v1_r, done_r;
      logic [FOLD_W-1:0] fold_r;
      logic [QW-1:0]     quot_r;
      logic [AW-1:0]     rem_r;
      logic [PW-1:0]     prod;
      logic [MW-1:0]     back;
      logic [MW-1:0]     diff;

      // quotient by reciprocal multiply, exact for a 16-bit fold when the depth is above 8
      assign prod = PW'(fold) * PW'(RECIP);

      // remainder: multiply the quotient back and subtract
      assign back = MW'(quot_r) * MW'(DEPTH_W);
      assign diff = MW'(fold_r) - back;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          v1_r   <= start;
          done_r <= v1_r;
        end
        if (start) begin
          fold_r <= fold;
          quot_r <= prod[PW-1:32];
        end
        if (v1_r) begin
          rem_r <= diff[AW-1:0];
        end
      end

      assign done = done_r;
      assign idx  = rem_r;
    end
  endgenerate

endmodule

`default_nettype wire

[tb/tb.sv]
// tb: self-checking bench for mac_learning_forwarder_core, learn and forward decisions
// depends on rtl/mlf_pkg.sv, rtl/mlf_ifs.sv and the core with its submodules
// frames are scored against an in-bench mac table model under several port masks
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlf_pkg::*;

  localparam int TBL_DEPTH   = TABLE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASES      = 5;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
  } frame_t;

  typedef struct packed {
    logic              flood;
    logic [PORT_W-1:0] port;
    logic [MASK_W-1:0] mask;
  } decision_t;

  logic clk;
  logic rst_n;

  mlf_in_if  in_bus ();
  mlf_out_if out_bus ();
  mlf_cfg_if cfg_bus ();

  mac_learning_forwarder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // model state: learned table and connected-port mask
  bit                tbl_valid [TBL_DEPTH];
  logic [MAC_W-1:0]  tbl_tag   [TBL_DEPTH];
  logic [PORT_W-1:0] tbl_port  [TBL_DEPTH];
  logic [MASK_W-1:0] port_mask_now = '0;

  frame_t      pending_frames [$];
  decision_t   due_decisions [$];
  logic [MAC_W-1:0] mac_pool [POOL_SIZE];

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_armed = 1'b0;
  bit  hold_started = 1'b0;
  int  hold_left = 0;
  bit  in_fire = 1'b0;
  int  fail_count = 0;
  int  quiet_cycles = 0;
  frame_t    seen_frame;
  decision_t want;

  // clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // table slot of a mac: 16-bit xor fold, then modulo depth
  function automatic int table_slot(logic [MAC_W-1:0] mac);
    logic [15:0] fold;
    fold = mac[15:0] ^ mac[31:16] ^ mac[47:32];
    return int'(fold) % TBL_DEPTH;
  endfunction

  // learn the source, look up the destination, build the decision
  function automatic decision_t forward_decision(frame_t f);
    decision_t d;
    int s_slot;
    int d_slot;
    logic [PORT_W-1:0] hit_port;
    hit_port = '0;
    if (f.dst != BCAST_MAC) begin
      s_slot = table_slot(f.src);
      tbl_valid[s_slot] = 1'b1;
      tbl_tag[s_slot]   = f.src;
      tbl_port[s_slot]  = f.port;
      d_slot = table_slot(f.dst);
      if (tbl_valid[d_slot] && tbl_tag[d_slot] == f.dst) hit_port = tbl_port[d_slot];
    end
    if (hit_port != '0) begin
      d.flood = 1'b0;
      d.port  = hit_port;
      d.mask  = 32'h1 << hit_port;
    end else begin
      d.flood = 1'b1;
      d.port  = '0;
      d.mask  = port_mask_now & ~32'h1 & ~(32'h1 << f.port);
    end
    return d;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), $urandom};
  endfunction

  // random frame, biased toward a small mac pool so lookups hit
  function automatic frame_t random_frame();
    frame_t f;
    int pick;
    f.port = ($urandom_range(15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    pick = $urandom_range(99);
    if (pick < 65) f.src = mac_pool[$urandom_range(POOL_SIZE - 1)];
    else if (pick < 68) f.src = BCAST_MAC;
    else f.src = random_mac();
    pick = $urandom_range(99);
    if (pick < 10) f.dst = BCAST_MAC;
    else if (pick < 65) f.dst = mac_pool[$urandom_range(POOL_SIZE - 1)];
    else f.dst = random_mac();
    return f;
  endfunction

  task automatic add_frame(logic [PORT_W-1:0] port, logic [MAC_W-1:0] src,
                           logic [MAC_W-1:0] dst);
    frame_t f;
    f.port = port;
    f.src  = src;
    f.dst  = dst;
    pending_frames.push_back(f);
  endtask

  // one config beat carrying the port mask
  task automatic write_port_mask(logic [MASK_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    port_mask_now = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // block until every frame is sent and every decision has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_frames.size() != 0 || in_bus.valid || due_decisions.size() != 0);
  endtask

  // frame driver, one beat per handshake
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (pending_frames.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_bus.valid        <= 1'b1;
        in_bus.ingress_port <= pending_frames[0].port;
        in_bus.source_mac   <= pending_frames[0].src;
        in_bus.dest_mac     <= pending_frames[0].dst;
        void'(pending_frames.pop_front());
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // decision receiver, random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_armed && !hold_started) begin
      hold_started  <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: predict on each frame beat, score each decision beat
  always @(posedge clk) begin
    in_fire <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      seen_frame.port = in_bus.ingress_port;
      seen_frame.src  = in_bus.source_mac;
      seen_frame.dst  = in_bus.dest_mac;
      due_decisions.push_back(forward_decision(seen_frame));
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (due_decisions.size() == 0) begin
        $error("decision beat with no frame outstanding");
        fail_count++;
      end else begin
        want = due_decisions.pop_front();
        if (out_bus.is_flood !== want.flood) begin
          $error("is_flood mismatch: expected %0d actual %0d", want.flood, out_bus.is_flood);
          fail_count++;
        end
        if (out_bus.forward_port !== want.port) begin
          $error("forward_port mismatch: expected %0d actual %0d", want.port,
                 out_bus.forward_port);
          fail_count++;
        end
        if (out_bus.egress_mask !== want.mask) begin
          $error("egress_mask mismatch: expected %08h actual %08h", want.mask,
                 out_bus.egress_mask);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("mac_learning_forwarder_core verification failed");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [MAC_W-1:0] mac_a;
    logic [MAC_W-1:0] mac_a2;
    logic [MAC_W-1:0] mac_a3;
    logic [MAC_W-1:0] mac_b;
    logic [MASK_W-1:0] phase_mask [PHASES];
    int n_rand;

    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.ingress_port = '0;
    in_bus.source_mac   = '0;
    in_bus.dest_mac     = '0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.data        = '0;

    // mac pool with same-slot neighbors so entries get overwritten
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 4 == 1) begin
        mac_pool[i] = mac_pool[i-1] ^ {16'h0, {2{16'($urandom_range(1, 65535))}}};
      end else if (i % 4 == 2) begin
        mac_pool[i] = mac_pool[i-2] ^ (48'($urandom_range(1, 63)) << 10);
      end else begin
        mac_pool[i] = random_mac();
      end
    end

    phase_mask[0] = 32'hFFFF_FFFF;
    phase_mask[1] = 32'h0000_0000;
    phase_mask[2] = $urandom;
    phase_mask[3] = 32'h7FFF_FFFE;
    phase_mask[4] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      write_port_mask(phase_mask[ph]);
      if (ph < 2) begin
        tx_idle_pct = 23;
        rx_idle_pct = 62;
      end else if (ph < 4) begin
        tx_idle_pct = 62;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      n_rand = 130;
      if (ph == 0) begin
        n_rand = 110;
        mac_a  = 48'h0200_0000_00A1;
        mac_a2 = mac_a ^ 48'h0000_1234_1234;
        mac_a3 = mac_a2 ^ 48'h0000_0000_0C00;
        mac_b  = 48'h0200_0000_00B2;
        // broadcast floods and learns nothing
        add_frame(5'd1, mac_a, BCAST_MAC);
        add_frame(5'd31, mac_b, mac_a);
        add_frame(5'd5, mac_a, mac_b);
        // source equals destination forwards back to ingress
        add_frame(5'd7, 48'h0200_0000_00C3, 48'h0200_0000_00C3);
        // broadcast source is learned, all-zero destination misses
        add_frame(5'd9, BCAST_MAC, 48'h0);
        add_frame(5'd3, 48'h0, BCAST_MAC);
        add_frame(5'd0, 48'h0200_0000_00E5, BCAST_MAC);
        // ingress port zero is learned, later hit on it floods
        add_frame(5'd0, 48'h0200_0000_00E5, mac_a);
        add_frame(5'd12, 48'h0200_0000_00F6, 48'h0200_0000_00E5);
        // slot collision overwrites the older mac
        add_frame(5'd2, mac_a2, mac_a);
        add_frame(5'd6, 48'h0200_0000_0107, mac_a2);
        add_frame(5'd31, 48'h0, 48'h0);
        add_frame(5'd1, 48'h0200_0000_0118, 48'h0);
        add_frame(5'd17, mac_a3, mac_a2);
        add_frame(5'd30, 48'h0000_0000_0001, mac_a3);
        add_frame(5'd16, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFE);
        add_frame(5'd8, 48'hFFFF_FFFF_FFFE, BCAST_MAC);
        add_frame(5'd20, 48'h0200_0000_0129, mac_b);
        add_frame(5'd31, 48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA);
      end

      repeat (n_rand) pending_frames.push_back(random_frame());
      // long receiver hold-off while the sender keeps offering frames
      if (ph == PHASES - 1) hold_armed = 1'b1;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("mac_learning_forwarder_core verification clean");
    end else begin
      $display("mac_learning_forwarder_core verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mlf_pkg.sv
rtl/mlf_ifs.sv
rtl/mlf_ram.sv
rtl/mlf_idx_unit.sv
rtl/mac_learning_forwarder_core.sv
tb/tb.sv
